[rtl/xbt_pkg.sv]
`default_nettype none
package xbt_pkg;

	localparam int OP_W = 4;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT    = 4'd0,
		OP_REMOVE    = 4'd1,
		OP_CONTAINS  = 4'd2,
		OP_SELECT    = 4'd3,
		OP_POP       = 4'd4,
		OP_RANK_LESS = 4'd5,
		OP_RANK_LE   = 4'd6,
		OP_XOR_ALL   = 4'd7,
		OP_GT        = 4'd8,
		OP_LT        = 4'd9,
		OP_GE        = 4'd10,
		OP_LE        = 4'd11
	} op_t;

endpackage
`default_nettype wire

[rtl/xbt_count_ram.sv]
`default_nettype none
module xbt_count_ram #(
	parameter int AW = 11,
	parameter int DW = 11
) (
	input  wire logic          clk,
	input  wire logic          wen,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

[rtl/xor_binary_trie_order_set.sv]
`default_nettype none
// Order-statistic set of distinct keys with a global xor applied to all members.
// Command channel: opcode/key/position transfer when start is high and busy is low.
// Result channel: value/found/rank/count are valid for the single cycle that done
// is high; there is no backpressure, the receiver must take it then. count also
// tracks the member count between results.
// Command paths: xor_all, unused opcodes and select/pop out of range finish
// straight from idle; contains, insert of a member and remove of a non-member
// read the leaf counter; an insert or remove that changes the set also updates
// every counter from the leaf up to the root; rank_less and rank_le walk the
// key path; select walks down by position; pop selects and then updates the
// counters; gt, lt, ge and le first walk the key path, then select.
// One item at a time. The subtree counts live in one memory with one read and one
// write port and registered read data; every tree walk touches one node per cycle.
// After reset the count memory is cleared one entry per cycle, all 2^(KEY_BITS+1)
// entries; busy stays high through the clear, so no command is taken before it ends.
module xor_binary_trie_order_set #(
	parameter int KEY_BITS = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [xbt_pkg::OP_W-1:0]  opcode,
	input  wire logic [KEY_BITS-1:0]       key,
	input  wire logic signed [KEY_BITS:0]  position,
	output logic                           busy,
	output logic                           done,
	output logic [KEY_BITS-1:0]            value,
	output logic                           found,
	output logic [KEY_BITS:0]              rank,
	output logic [KEY_BITS:0]              count
);
	import xbt_pkg::*;

	localparam int KB    = KEY_BITS;
	localparam int AW    = KEY_BITS + 1;
	localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(KEY_BITS - 1);

	typedef enum logic [10:0] {
		S_CLEAR    = 11'b00000000001,
		S_IDLE     = 11'b00000000010,
		S_LEAF     = 11'b00000000100,
		S_LEAF_END = 11'b00000001000,
		S_RANK     = 11'b00000010000,
		S_RANK_LF  = 11'b00000100000,
		S_RANK_END = 11'b00001000000,
		S_SEL_RD   = 11'b00010000000,
		S_SEL      = 11'b00100000000,
		S_UPD      = 11'b01000000000,
		S_UPD_WB   = 11'b10000000000
	} state_t;

	state_t           state_q;
	logic             done_q;
	logic [KB:0]      count_q;
	logic [KB-1:0]    mask_q;
	logic [AW-1:0]    clr_q;
	logic             wr_pend_q;
	logic             acc_pend_q;

	logic [OP_W-1:0]  op_q;
	logic [KB-1:0]    key_q;
	logic [KB-1:0]    path_q;
	logic [LVL_W-1:0] lvl_q;
	logic [AW-1:0]    node_q;
	logic [KB:0]      acc_q;
	logic [KB:0]      sel_k_q;
	logic [KB-1:0]    res_q;
	logic [AW-1:0]    upd_node_q;
	logic             dec_q;
	logic [AW-1:0]    wr_addr_q;
	logic [KB-1:0]    value_q;
	logic             found_q;
	logic [KB:0]      rank_q;

	logic             wen;
	logic [AW-1:0]    waddr;
	logic [KB:0]      wdata;
	logic [AW-1:0]    raddr;
	logic [KB:0]      rdata;

	// select step
	logic             mb;
	logic             go_lo;
	logic [AW-1:0]    node_nx;
	logic [KB:0]      k_nx;
	logic [KB:0]      res_sh;
	logic [KB-1:0]    res_nx;
	logic [LVL_W-1:0] lvl_m1;

	// rank result
	logic             present;
	logic [KB:0]      rle;
	logic [KB:0]      rk_base;
	logic             rk_minus;
	logic             rk_ok;
	logic [KB:0]      rk_k;

	// position for select/pop
	logic [KB+1:0]    posx;
	logic             pos_ok;
	logic [KB:0]      pos_k;

	xbt_count_ram #(
		.AW(AW),
		.DW(KB + 1)
	) u_ram (
		.clk  (clk),
		.wen  (wen),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		mb      = mask_q[lvl_q];
		go_lo   = sel_k_q < rdata;
		node_nx = {node_q[KB-1:0], go_lo ? mb : ~mb};
		k_nx    = go_lo ? sel_k_q : sel_k_q - rdata;
		res_sh  = {res_q, ~go_lo};
		res_nx  = res_sh[KB-1:0];
		lvl_m1  = (lvl_q == '0) ? '0 : lvl_q - 1'b1;
	end

	always_comb begin
		present  = |rdata;
		rle      = acc_q + {{KB{1'b0}}, present};
		rk_base  = (op_q == OP_GT || op_q == OP_LE) ? rle : acc_q;
		rk_minus = (op_q == OP_LT || op_q == OP_LE);
		rk_ok    = rk_minus ? (rk_base != '0) : (rk_base < count_q);
		rk_k     = rk_minus ? rk_base - 1'b1 : rk_base;
	end

	always_comb begin
		posx   = {position[KB], position} + {1'b0, count_q};
		if (position[KB]) begin
			pos_ok = !posx[KB+1];
			pos_k  = posx[KB:0];
		end else begin
			pos_k  = {1'b0, position[KB-1:0]};
			pos_ok = pos_k < count_q;
		end
	end

	always_comb begin
		unique case (state_q)
			S_LEAF, S_RANK_LF: raddr = {1'b1, path_q};
			S_RANK, S_SEL_RD:  raddr = {node_q[KB-1:0], mb};
			S_SEL:             raddr = {node_nx[KB-1:0], mask_q[lvl_m1]};
			S_UPD:             raddr = upd_node_q;
			default:           raddr = '0;
		endcase
	end

	assign wen   = (state_q == S_CLEAR) || wr_pend_q;
	assign waddr = (state_q == S_CLEAR) ? clr_q : wr_addr_q;
	assign wdata = (state_q == S_CLEAR) ? '0 : (dec_q ? rdata - 1'b1 : rdata + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			done_q     <= 1'b0;
			count_q    <= '0;
			mask_q     <= '0;
			clr_q      <= '0;
			wr_pend_q  <= 1'b0;
			acc_pend_q <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			wr_pend_q  <= 1'b0;
			acc_pend_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						unique case (opcode) inside
							OP_INSERT, OP_REMOVE, OP_CONTAINS: state_q <= S_LEAF;
							OP_SELECT, OP_POP: begin
								if (pos_ok) state_q <= S_SEL_RD;
								else done_q <= 1'b1;
							end
							OP_RANK_LESS, OP_RANK_LE, OP_GT, OP_LT, OP_GE, OP_LE:
								state_q <= S_RANK;
							OP_XOR_ALL: begin
								mask_q <= mask_q ^ key;
								done_q <= 1'b1;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_LEAF: state_q <= S_LEAF_END;
				S_LEAF_END: begin
					if ((op_q == OP_INSERT && !present) || (op_q == OP_REMOVE && present)) begin
						state_q <= S_UPD;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RANK: begin
					acc_pend_q <= key_q[lvl_q];
					if (lvl_q == '0) state_q <= S_RANK_LF;
				end
				S_RANK_LF: state_q <= S_RANK_END;
				S_RANK_END: begin
					if (op_q == OP_RANK_LESS || op_q == OP_RANK_LE || !rk_ok) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SEL_RD;
					end
				end
				S_SEL_RD: state_q <= S_SEL;
				S_SEL: begin
					if (lvl_q == '0) begin
						if (op_q == OP_POP) begin
							state_q <= S_UPD;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_UPD: begin
					wr_pend_q <= 1'b1;
					if (upd_node_q == AW'(1)) state_q <= S_UPD_WB;
				end
				S_UPD_WB: begin
					count_q <= dec_q ? count_q - 1'b1 : count_q + 1'b1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_pend_q) acc_q <= acc_q + rdata;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q    <= opcode;
					key_q   <= key;
					path_q  <= key ^ mask_q;
					lvl_q   <= TOP_LVL;
					node_q  <= AW'(1);
					acc_q   <= '0;
					res_q   <= '0;
					sel_k_q <= pos_k;
					value_q <= '0;
					rank_q  <= '0;
					found_q <= (opcode == OP_XOR_ALL);
				end
			end
			S_LEAF_END: begin
				found_q    <= (op_q == OP_INSERT) ? !present :
				              (op_q == OP_REMOVE || op_q == OP_CONTAINS) ? present : 1'b0;
				upd_node_q <= {1'b1, path_q};
				dec_q      <= (op_q == OP_REMOVE);
			end
			S_RANK: begin
				node_q <= {node_q[KB-1:0], path_q[lvl_q]};
				lvl_q  <= lvl_m1;
			end
			S_RANK_END: begin
				rank_q  <= (op_q == OP_RANK_LESS) ? acc_q :
				           (op_q == OP_RANK_LE) ? rle : '0;
				found_q <= (op_q == OP_RANK_LESS || op_q == OP_RANK_LE);
				sel_k_q <= rk_k;
				node_q  <= AW'(1);
				lvl_q   <= TOP_LVL;
			end
			S_SEL: begin
				node_q  <= node_nx;
				sel_k_q <= k_nx;
				res_q   <= res_nx;
				lvl_q   <= lvl_m1;
				if (lvl_q == '0) begin
					value_q    <= res_nx;
					found_q    <= 1'b1;
					upd_node_q <= node_nx;
					dec_q      <= 1'b1;
				end
			end
			S_UPD: begin
				wr_addr_q  <= upd_node_q;
				upd_node_q <= upd_node_q >> 1;
			end
			default: ;
		endcase
	end

	assign busy  = (state_q != S_IDLE);
	assign done  = done_q;
	assign value = value_q;
	assign found = found_q;
	assign rank  = rank_q;
	assign count = count_q;

endmodule
`default_nettype wire

[rtl/xbt_checker.sv]
`default_nettype none
module xbt_checker #(
	parameter int KEY_BITS = 10
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic [xbt_pkg::OP_W-1:0] opcode,
	input wire logic                     busy,
	input wire logic                     done,
	input wire logic                     found,
	input wire logic [KEY_BITS:0]        count
);
	import xbt_pkg::*;

	// a result never shows while a command is still in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// every accepted command either keeps the block busy or returns at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command vanished");

	a_xor_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_XOR_ALL) |=> (done && found))
		else $error("xor_all did not return in one cycle");

	// member count only moves with a successful result, by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count) |-> (done && found &&
			(count == $past(count) + 1'b1 || count == $past(count) - 1'b1)))
		else $error("member count changed without a transfer");

endmodule

bind xor_binary_trie_order_set xbt_checker #(.KEY_BITS(KEY_BITS)) u_xbt_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.opcode(opcode),
	.busy  (busy),
	.done  (done),
	.found (found),
	.count (count)
);
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import xbt_pkg::*;

	localparam int KB = 10;
	localparam int KEY_SPAN = 1 << KB;
	localparam int RANDOM_CMDS = 450;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd12;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

	typedef struct {
		logic [OP_W-1:0]  opcode;
		logic [KB-1:0]    key;
		logic signed [KB:0] position;
		int               idle_pct;
	} cmd_t;

	typedef struct {
		logic [KB-1:0] value;
		logic          found;
		logic [KB:0]   rank;
		logic [KB:0]   count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [OP_W-1:0] opcode = '0;
	logic [KB-1:0] key = '0;
	logic signed [KB:0] position = '0;
	logic busy, done;
	logic [KB-1:0] value;
	logic found;
	logic [KB:0] rank, count;

	xor_binary_trie_order_set #(.KEY_BITS(KB)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode), .key(key),
		.position(position), .busy(busy), .done(done), .value(value), .found(found),
		.rank(rank), .count(count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the set: membership indexed by stored key, logical = stored ^ mask
	bit stored_member [KEY_SPAN];
	logic [KB-1:0] key_mask = '0;
	int member_total = 0;
	int peak_members = 0;
	int pops_done = 0;

	cmd_t pending_q [$];
	outcome_t expected_q [$];
	cmd_t drv_item, sent_item;
	outcome_t mon_want;
	int errors = 0;
	int cmds_sent = 0;
	int results_checked = 0;

	function automatic bit is_member(logic [KB-1:0] v);
		return stored_member[v ^ key_mask];
	endfunction

	function automatic int count_below(logic [KB-1:0] k);
		int n;
		n = 0;
		for (int v = 0; v < k; v++)
			if (is_member(KB'(v)))
				n++;
		return n;
	endfunction

	function automatic logic [KB-1:0] nth_member(int k);
		for (int v = 0; v < KEY_SPAN; v++)
			if (is_member(KB'(v))) begin
				if (k == 0)
					return KB'(v);
				k--;
			end
		return '0;
	endfunction

	function automatic void set_member(logic [KB-1:0] v, bit on);
		stored_member[v ^ key_mask] = on;
		member_total += on ? 1 : -1;
		if (member_total > peak_members)
			peak_members = member_total;
	endfunction

	function automatic outcome_t apply_command(cmd_t c);
		outcome_t r;
		int sel;
		bit want_sel;
		r = '{value: '0, found: 1'b0, rank: '0, count: '0};
		sel = 0;
		want_sel = 1'b0;
		case (c.opcode)
			OP_INSERT: if (!is_member(c.key)) begin
				set_member(c.key, 1'b1);
				r.found = 1'b1;
			end
			OP_REMOVE: if (is_member(c.key)) begin
				set_member(c.key, 1'b0);
				r.found = 1'b1;
			end
			OP_CONTAINS: r.found = is_member(c.key);
			OP_SELECT, OP_POP: begin
				sel = (c.position < 0) ? int'(c.position) + member_total : int'(c.position);
				want_sel = 1'b1;
			end
			OP_RANK_LESS: begin
				r.rank = (KB+1)'(count_below(c.key));
				r.found = 1'b1;
			end
			OP_RANK_LE: begin
				r.rank = (KB+1)'(count_below(c.key) + is_member(c.key));
				r.found = 1'b1;
			end
			OP_XOR_ALL: begin
				key_mask ^= c.key;
				r.found = 1'b1;
			end
			OP_GT: begin
				sel = count_below(c.key) + is_member(c.key);
				want_sel = 1'b1;
			end
			OP_LT: begin
				sel = count_below(c.key) - 1;
				want_sel = 1'b1;
			end
			OP_GE: begin
				sel = count_below(c.key);
				want_sel = 1'b1;
			end
			OP_LE: begin
				sel = count_below(c.key) + is_member(c.key) - 1;
				want_sel = 1'b1;
			end
			default: ;
		endcase
		if (want_sel && sel >= 0 && sel < member_total) begin
			r.value = nth_member(sel);
			r.found = 1'b1;
			if (c.opcode == OP_POP) begin
				set_member(r.value, 1'b0);
				pops_done++;
			end
		end
		r.count = (KB+1)'(member_total);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// driver: holds start until the transfer, then presents the next queued command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				sent_item.opcode = opcode;
				sent_item.key = key;
				sent_item.position = position;
				expected_q.push_back(apply_command(sent_item));
				cmds_sent++;
			end
			if (!start || !busy) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].idle_pct) begin
					drv_item = pending_q.pop_front();
					start <= 1'b1;
					opcode <= drv_item.opcode;
					key <= drv_item.key;
					position <= drv_item.position;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every done strobe must match the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing outstanding, count", count, 0);
			end else begin
				mon_want = expected_q.pop_front();
				results_checked++;
				if (value !== mon_want.value)
					report_mismatch("value", value, mon_want.value);
				if (found !== mon_want.found)
					report_mismatch("found", found, mon_want.found);
				if (rank !== mon_want.rank)
					report_mismatch("rank", rank, mon_want.rank);
				if (count !== mon_want.count)
					report_mismatch("count", count, mon_want.count);
			end
		end
	end

	task automatic add_cmd(logic [OP_W-1:0] op, int k, int p, int pct);
		cmd_t c;
		c.opcode = op;
		c.key = KB'(k);
		c.position = (KB+1)'(p);
		c.idle_pct = pct;
		pending_q.push_back(c);
	endtask

	function automatic logic [OP_W-1:0] spare_opcode();
		return OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
	endfunction

	initial begin
		logic [KB-1:0] used_keys [$];
		logic [OP_W-1:0] op;
		int r, k, p, pct;

		// directed: empty-set selects, duplicates, range edges, greatest-key le
		add_cmd(OP_SELECT, 0, 0, 0);
		add_cmd(OP_POP, 0, -1, 0);
		add_cmd(OP_LE, KEY_SPAN - 1, 0, 0);
		add_cmd(OP_INSERT, 0, 0, 0);
		add_cmd(OP_INSERT, KEY_SPAN - 1, 0, 0);
		add_cmd(OP_INSERT, 0, 0, 0);
		add_cmd(OP_INSERT, 512, 0, 0);
		add_cmd(OP_CONTAINS, KEY_SPAN - 1, 0, 0);
		add_cmd(OP_CONTAINS, 5, 0, 0);
		add_cmd(OP_SELECT, 0, -1, 0);
		add_cmd(OP_SELECT, 0, -3, 0);
		add_cmd(OP_SELECT, 0, 3, 0);
		add_cmd(OP_SELECT, 0, -4, 0);
		add_cmd(OP_SELECT, 0, -1024, 0);
		add_cmd(OP_SELECT, 0, 1023, 0);
		add_cmd(OP_RANK_LESS, KEY_SPAN - 1, 0, 0);
		add_cmd(OP_RANK_LE, KEY_SPAN - 1, 0, 0);
		add_cmd(OP_GT, KEY_SPAN - 1, 0, 0);
		add_cmd(OP_LT, 0, 0, 0);
		add_cmd(OP_LE, KEY_SPAN - 1, 0, 0);
		add_cmd(OP_XOR_ALL, KEY_SPAN - 1, 0, 0);
		add_cmd(OP_POP, 0, 0, 0);
		add_cmd(OP_REMOVE, 511, 0, 0);
		add_cmd(OP_REMOVE, 7, 0, 0);
		add_cmd(OP_GE, 1, 0, 0);
		add_cmd(OP_SPARE_HI, 3, 0, 0);

		// random: insert-heavy so the set grows and order queries see real depth
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			case (i * 4 / RANDOM_CMDS)
				0: pct = 0;
				1: pct = 66;
				2: pct = 25;
				default: pct = 0;
			endcase
			r = $urandom_range(99);
			if (r < 30) op = OP_INSERT;
			else if (r < 40) op = OP_REMOVE;
			else if (r < 47) op = OP_CONTAINS;
			else if (r < 54) op = OP_SELECT;
			else if (r < 60) op = OP_POP;
			else if (r < 65) op = OP_RANK_LESS;
			else if (r < 70) op = OP_RANK_LE;
			else if (r < 73) op = OP_XOR_ALL;
			else if (r < 78) op = OP_GT;
			else if (r < 83) op = OP_LT;
			else if (r < 88) op = OP_GE;
			else if (r < 93) op = OP_LE;
			else if (r < 95) op = spare_opcode();
			else op = OP_INSERT;
			if (used_keys.size() != 0 && $urandom_range(1) == 1)
				k = used_keys[$urandom_range(used_keys.size() - 1)];
			else
				k = $urandom_range(KEY_SPAN - 1);
			if (op == OP_INSERT)
				used_keys.push_back(KB'(k));
			r = $urandom_range(99);
			if (r < 60)
				p = int'($urandom_range(320)) - 160;
			else if (r < 80)
				p = int'($urandom_range(2047)) - 1024;
			else
				case ($urandom_range(3))
					0: p = -1024;
					1: p = 1023;
					2: p = -1;
					default: p = 0;
				endcase
			add_cmd(op, k, p, pct);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_q.size() != 0 || expected_q.size() != 0 || start);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d commands and %0d checked results across four idle phases",
			cmds_sent, results_checked);
		$display("set reached %0d members, %0d successful pops, final mask %0d",
			peak_members, pops_done, key_mask);
		if (errors == 0)
			$display("xor_binary_trie_order_set: match");
		else
			$display("xor_binary_trie_order_set: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("xor_binary_trie_order_set: mismatch");
		$finish;
	end

endmodule
